[src/lkvc_pkg.sv]
`default_nettype none
package lkvc_pkg;

  localparam int ENTRIES_DEFAULT = 16;
  localparam int KEY_W           = 32;
  localparam int VALUE_W         = 32;
  localparam int CAP_W           = 5;

  localparam logic [CAP_W-1:0]   CAP_RESET  = 5'd16;
  localparam logic [VALUE_W-1:0] MISS_VALUE = 32'hFFFF_FFFF;

  localparam logic FUNC_LOOKUP = 1'b0;
  localparam logic FUNC_WRITE  = 1'b1;

endpackage
`default_nettype wire

[src/lru_key_value_cache_core.sv]
// fully associative key/value cache with least-recently-used replacement
//
// input stream: s_axis_tuser[0] selects lookup (0) or write (1), s_axis_tdata carries
// key in the low word and value in the high word. a lookup gives one output transfer,
// m_axis_tuser[0] = hit and m_axis_tdata = stored value, or all ones on a miss. a write
// gives no output transfer. cfg_wr_en/cfg_wr_data set the capacity in use (0 acts as 1,
// values above ENTRIES act as ENTRIES); write it only while the block is idle.
//
// one key compare unit and one rank update unit are stepped over the entries, one entry
// a cycle, against registered-read key, value and rank memories. after the accept cycle
// an item searches all entries and then decides; a lookup hit then reads its value, a
// hit or any write then updates the ranks of all entries, and a final state hands any
// result to the output register. a new item is taken only once the last one is done:
// s_axis_tready is high only between items. while m_axis_tready is low a new item is
// still taken; a further lookup waits at its end until the output register is free.
//
// reset clears all valid bits, the entry count and the output valid flag, and sets the
// capacity to 16; key, value and rank memories are not cleared, valid bits guard them.
`default_nettype none
module lru_key_value_cache_core #(
  parameter int ENTRIES = lkvc_pkg::ENTRIES_DEFAULT
) (
  input  logic clk,
  input  logic rst,
  // cfg
  input  logic                          cfg_wr_en,
  input  logic [lkvc_pkg::CAP_W-1:0]    cfg_wr_data,   // capacity_in_use
  // input stream
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [lkvc_pkg::KEY_W+lkvc_pkg::VALUE_W-1:0] s_axis_tdata, // key, value
  input  logic [0:0]                    s_axis_tuser,  // func
  // output stream
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [lkvc_pkg::VALUE_W-1:0]  m_axis_tdata,  // read_value
  output logic [0:0]                    m_axis_tuser   // hit
);

  import lkvc_pkg::*;

  localparam int IW   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CW   = $clog2(ENTRIES + 1);
  localparam int CMPW = (CW > CAP_W) ? CW : CAP_W;

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_SCAN   = 3'd1;
  localparam logic [2:0] ST_DECIDE = 3'd2;
  localparam logic [2:0] ST_VALUE  = 3'd3;
  localparam logic [2:0] ST_UPDATE = 3'd4;
  localparam logic [2:0] ST_FINISH = 3'd5;

  logic [2:0]         state;
  logic [CW-1:0]      cnt;
  logic               rd_pending;
  logic [IW-1:0]      rd_idx;
  logic [ENTRIES-1:0] valid;
  logic [CW-1:0]      used;
  logic [CAP_W-1:0]   cap;
  logic               out_valid;
  logic               out_hit;
  logic [VALUE_W-1:0] out_data;

  logic               op_func;
  logic [KEY_W-1:0]   op_key;
  logic [VALUE_W-1:0] op_value;

  logic               found;
  logic [IW-1:0]      found_idx;
  logic [IW-1:0]      found_rank;
  logic               any_valid;
  logic [IW-1:0]      victim_idx;
  logic [IW-1:0]      victim_rank;
  logic               free_found;
  logic [IW-1:0]      free_idx;
  logic [IW-1:0]      target_idx;
  logic [IW-1:0]      old_rank;
  logic               age_all;
  logic               pend_result;
  logic               pend_hit;
  logic [VALUE_W-1:0] pend_data;

  logic [IW-1:0]      scan_addr;
  logic [KEY_W-1:0]   key_rdata;
  logic [VALUE_W-1:0] value_rdata;
  logic [IW-1:0]      rank_rdata;
  logic               key_we;
  logic               value_we;
  logic [IW-1:0]      wr_idx;
  logic               rank_we;
  logic [IW-1:0]      rank_wdata;
  logic               is_target;
  logic               ages;
  logic [CMPW-1:0]    cap_ext;
  logic [CMPW-1:0]    cap_eff;
  logic               room;
  logic               out_free;
  logic               in_xfer;

  assign s_axis_tready = (state == ST_IDLE);
  assign in_xfer       = s_axis_tvalid && s_axis_tready;
  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = out_data;
  assign m_axis_tuser  = out_hit;
  assign out_free      = !out_valid || m_axis_tready;

  assign scan_addr = (cnt < CW'(ENTRIES)) ? cnt[IW-1:0] : '0;

  // capacity clamped to 1..ENTRIES
  always_comb begin
    cap_ext = CMPW'(cap);
    cap_eff = cap_ext;
    if (cap_ext == '0) begin
      cap_eff = CMPW'(1);
    end else if (cap_ext > CMPW'(ENTRIES)) begin
      cap_eff = CMPW'(ENTRIES);
    end
  end
  assign room = (CMPW'(used) < cap_eff) && (CMPW'(used) < CMPW'(ENTRIES));

  // insert target: free slot while below capacity, else least recent slot
  assign wr_idx   = found ? found_idx : (room ? free_idx : victim_idx);
  assign value_we = (state == ST_DECIDE) && (op_func == FUNC_WRITE);
  assign key_we   = value_we && !found;

  // rank update cell, one entry a cycle
  assign is_target  = (rd_idx == target_idx);
  assign ages       = valid[rd_idx] && (age_all || (rank_rdata < old_rank));
  assign rank_we    = (state == ST_UPDATE) && rd_pending && (is_target || ages);
  assign rank_wdata = is_target ? '0 : IW'(rank_rdata + 1'b1);

  lkvc_ram #(.WIDTH(KEY_W), .DEPTH(ENTRIES)) u_key_ram (
    .clk   (clk),
    .we    (key_we),
    .waddr (wr_idx),
    .wdata (op_key),
    .raddr (scan_addr),
    .rdata (key_rdata)
  );

  lkvc_ram #(.WIDTH(VALUE_W), .DEPTH(ENTRIES)) u_value_ram (
    .clk   (clk),
    .we    (value_we),
    .waddr (wr_idx),
    .wdata (op_value),
    .raddr (found_idx),
    .rdata (value_rdata)
  );

  lkvc_ram #(.WIDTH(IW), .DEPTH(ENTRIES)) u_rank_ram (
    .clk   (clk),
    .we    (rank_we),
    .waddr (rd_idx),
    .wdata (rank_wdata),
    .raddr (scan_addr),
    .rdata (rank_rdata)
  );

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      cnt        <= '0;
      rd_pending <= 1'b0;
      valid      <= '0;
      used       <= '0;
      cap        <= CAP_RESET;
      out_valid  <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        cap <= cfg_wr_data;
      end
      rd_pending <= ((state == ST_SCAN) || (state == ST_UPDATE)) && (cnt < CW'(ENTRIES));
      // a result loaded in the same cycle keeps the register full
      if (out_valid && m_axis_tready && !((state == ST_FINISH) && pend_result)) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (in_xfer) begin
            cnt   <= '0;
            state <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          if (cnt == CW'(ENTRIES)) begin
            state <= ST_DECIDE;
          end else begin
            cnt <= CW'(cnt + 1'b1);
          end
        end
        ST_DECIDE: begin
          cnt <= '0;
          if (op_func == FUNC_LOOKUP) begin
            state <= found ? ST_VALUE : ST_FINISH;
          end else begin
            if (!found && room) begin
              valid[free_idx] <= 1'b1;
              used            <= CW'(used + 1'b1);
            end
            state <= ST_UPDATE;
          end
        end
        ST_VALUE: begin
          state <= ST_UPDATE;
        end
        ST_UPDATE: begin
          if (cnt == CW'(ENTRIES)) begin
            state <= ST_FINISH;
          end else begin
            cnt <= CW'(cnt + 1'b1);
          end
        end
        ST_FINISH: begin
          if (!pend_result) begin
            state <= ST_IDLE;
          end else if (out_free) begin
            out_valid <= 1'b1;
            state     <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    rd_idx <= scan_addr;
    if (in_xfer) begin
      op_func     <= s_axis_tuser[0];
      op_key      <= s_axis_tdata[KEY_W-1:0];
      op_value    <= s_axis_tdata[KEY_W+VALUE_W-1:KEY_W];
      found       <= 1'b0;
      any_valid   <= 1'b0;
      free_found  <= 1'b0;
      pend_result <= (s_axis_tuser[0] == FUNC_LOOKUP);
      pend_hit    <= 1'b0;
      pend_data   <= MISS_VALUE;
    end
    if ((state == ST_SCAN) && rd_pending) begin
      if (valid[rd_idx] && (key_rdata == op_key) && !found) begin
        found      <= 1'b1;
        found_idx  <= rd_idx;
        found_rank <= rank_rdata;
      end
      if (valid[rd_idx] && (!any_valid || (rank_rdata > victim_rank))) begin
        any_valid   <= 1'b1;
        victim_idx  <= rd_idx;
        victim_rank <= rank_rdata;
      end
      if (!valid[rd_idx] && !free_found) begin
        free_found <= 1'b1;
        free_idx   <= rd_idx;
      end
    end
    if (state == ST_DECIDE) begin
      target_idx <= wr_idx;
      age_all    <= !found && room;
      old_rank   <= found ? found_rank : victim_rank;
    end
    if (state == ST_VALUE) begin
      pend_hit  <= 1'b1;
      pend_data <= value_rdata;
    end
    if ((state == ST_FINISH) && pend_result && out_free) begin
      out_hit  <= pend_hit;
      out_data <= pend_data;
    end
  end

  a_used_matches_valid: assert property (@(posedge clk) disable iff (rst)
    $countones(valid) == int'(used))
    else $error("entry count differs from number of valid slots");

  a_used_bounded: assert property (@(posedge clk) disable iff (rst)
    CMPW'(used) <= CMPW'(ENTRIES))
    else $error("entry count above number of slots");

  a_free_slot_known: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DECIDE && op_func == FUNC_WRITE && !found && room) |-> free_found)
    else $error("insert below capacity without a free slot");

  a_victim_known: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DECIDE && op_func == FUNC_WRITE && !found && !room) |-> any_valid)
    else $error("replacement without a valid victim");

  a_scan_runs: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SCAN && cnt != CW'(ENTRIES)) |=> state == ST_SCAN)
    else $error("search left before the last entry");

endmodule
`default_nettype wire

[src/lkvc_ram.sv]
`default_nettype none
module lkvc_ram #(
  parameter int WIDTH = lkvc_pkg::KEY_W,
  parameter int DEPTH = lkvc_pkg::ENTRIES_DEFAULT,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

[dv/tb_lru_key_value_cache_core.sv]
`timescale 1ns / 1ps
module tb_lru_key_value_cache_core;
  import lkvc_pkg::*;

  localparam int NSLOTS       = ENTRIES_DEFAULT;
  localparam int TAIL_CYCLES  = 2 * NSLOTS + 8;
  localparam int LIMIT_CYCLES = 600000;
  localparam int HOLD_CYCLES  = 400;
  localparam int NPHASES      = 9;

  typedef struct packed {
    logic               func;
    logic [KEY_W-1:0]   key;
    logic [VALUE_W-1:0] value;
  } cache_op_t;

  typedef struct packed {
    logic               hit;
    logic [VALUE_W-1:0] read_value;
  } lookup_answer_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_wr_en = 1'b0;
  logic [CAP_W-1:0] cfg_wr_data = '0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [KEY_W+VALUE_W-1:0] s_axis_tdata = '0;  // key, value
  logic [0:0] s_axis_tuser = '0;                 // func
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [VALUE_W-1:0] m_axis_tdata;              // read_value
  logic [0:0] m_axis_tuser;                      // hit

  lru_key_value_cache_core #(.ENTRIES(NSLOTS)) i_dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // predicted cache contents
  bit                 slot_valid [NSLOTS];
  logic [KEY_W-1:0]   slot_key   [NSLOTS];
  logic [VALUE_W-1:0] slot_value [NSLOTS];
  int unsigned        slot_age   [NSLOTS];
  int unsigned        slots_used;
  logic [CAP_W-1:0]   capacity;

  cache_op_t      pending_ops[$];
  lookup_answer_t lookup_expect[$];
  cache_op_t      offered_op;
  logic [KEY_W-1:0] key_base;

  int mismatches, results_seen, cycles;
  int n_lookups, n_hits, n_writes, n_evictions;

  task automatic make_most_recent(int s);
    int unsigned old_age;
    old_age = slot_age[s];
    for (int i = 0; i < NSLOTS; i++)
      if (slot_valid[i] && i != s && slot_age[i] < old_age) slot_age[i]++;
    slot_age[s] = 0;
  endtask

  task automatic lru_predict(cache_op_t op);
    int slot, victim;
    int unsigned eff_cap, oldest;
    lookup_answer_t ans;
    slot = -1;
    for (int i = 0; i < NSLOTS; i++)
      if (slot < 0 && slot_valid[i] && slot_key[i] == op.key) slot = i;
    if (op.func == FUNC_LOOKUP) begin
      n_lookups++;
      if (slot >= 0) begin
        n_hits++;
        ans.hit = 1'b1;
        ans.read_value = slot_value[slot];
        make_most_recent(slot);
      end else begin
        ans.hit = 1'b0;
        ans.read_value = MISS_VALUE;
      end
      lookup_expect.push_back(ans);
      return;
    end
    n_writes++;
    if (slot >= 0) begin
      slot_value[slot] = op.value;
      make_most_recent(slot);
      return;
    end
    eff_cap = (capacity == 0) ? 1 : (capacity > NSLOTS) ? NSLOTS : capacity;
    if (slots_used < eff_cap) begin
      // lowest free slot, everything else ages
      for (int i = 0; i < NSLOTS; i++)
        if (slot < 0 && !slot_valid[i]) slot = i;
      for (int i = 0; i < NSLOTS; i++)
        if (slot_valid[i]) slot_age[i]++;
      slot_valid[slot] = 1'b1;
      slot_key[slot]   = op.key;
      slot_value[slot] = op.value;
      slot_age[slot]   = 0;
      slots_used++;
      return;
    end
    victim = -1;
    oldest = 0;
    for (int i = 0; i < NSLOTS; i++)
      if (slot_valid[i] && (victim < 0 || slot_age[i] > oldest)) begin
        victim = i;
        oldest = slot_age[i];
      end
    if (victim < 0) return;
    n_evictions++;
    slot_key[victim]   = op.key;
    slot_value[victim] = op.value;
    make_most_recent(victim);
  endtask

  // driver: bursts of transfers separated by random gaps
  int burst_left, gap_left;
  always @(posedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
      burst_left = 0;
      gap_left = 0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) lru_predict(offered_op);
      if (!(s_axis_tvalid && !s_axis_tready)) begin
        if (gap_left > 0) begin
          gap_left--;
          s_axis_tvalid <= 1'b0;
        end else if (pending_ops.size() > 0) begin
          offered_op = pending_ops.pop_front();
          s_axis_tdata  <= {offered_op.value, offered_op.key};
          s_axis_tuser  <= offered_op.func;
          s_axis_tvalid <= 1'b1;
          if (burst_left == 0) burst_left = $urandom_range(1, 16);
          burst_left--;
          if (burst_left == 0) gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // receiver: stall pattern picked at random (always ready, random, one in four), plus one long hold-off
  int rx_tick, rx_mode, hold_left;
  bit hold_done;
  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
      rx_tick = 0;
      rx_mode = 0;
      hold_left = 0;
      hold_done = 1'b0;
    end else begin
      rx_tick++;
      if (rx_tick % 50 == 0) rx_mode = $urandom_range(0, 2);
      if (!hold_done && results_seen >= 150) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else begin
        case (rx_mode)
          0: m_axis_tready <= 1'b1;
          1: m_axis_tready <= 1'($urandom_range(0, 1));
          default: m_axis_tready <= (rx_tick % 4 == 0);
        endcase
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    lookup_answer_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      results_seen++;
      if (lookup_expect.size() == 0) begin
        $display("%0t: unexpected transfer hit=%0b value=%h", $time, m_axis_tuser[0],
                 m_axis_tdata);
        mismatches++;
      end else begin
        want = lookup_expect.pop_front();
        if (m_axis_tuser[0] !== want.hit) begin
          $display("%0t: hit expected %0b actual %0b", $time, want.hit, m_axis_tuser[0]);
          mismatches++;
        end
        if (m_axis_tdata !== want.read_value) begin
          $display("%0t: read_value expected %h actual %h", $time, want.read_value,
                   m_axis_tdata);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles >= LIMIT_CYCLES) begin
      $display("%0t: timed out, %0d lookups still outstanding", $time, lookup_expect.size());
      $display("Regression FAIL");
      $finish;
    end
  end

  task automatic push_op(logic func, logic [KEY_W-1:0] key, logic [VALUE_W-1:0] value);
    cache_op_t op;
    op.func  = func;
    op.key   = key;
    op.value = value;
    pending_ops.push_back(op);
  endtask

  function automatic cache_op_t random_op(int unsigned pool);
    cache_op_t op;
    int unsigned pick;
    pick = $urandom_range(0, 99);
    op.func = $urandom_range(0, 1) ? FUNC_WRITE : FUNC_LOOKUP;
    if (pick < 85) op.key = key_base ^ $urandom_range(0, pool - 1);
    else if (pick < 93) op.key = $urandom();
    else begin
      case ($urandom_range(0, 3))
        0: op.key = 32'h0000_0000;
        1: op.key = 32'hFFFF_FFFF;
        2: op.key = 32'h8000_0000;
        default: op.key = 32'h7FFF_FFFF;
      endcase
    end
    op.value = ($urandom_range(0, 9) == 0) ? {VALUE_W{pick[0]}} : $urandom();
    return op;
  endfunction

  // idle once everything has drained, plus the block's own processing time
  task automatic wait_idle();
    while (pending_ops.size() > 0 || s_axis_tvalid || lookup_expect.size() > 0)
      @(negedge clk);
    repeat (TAIL_CYCLES) @(negedge clk);
  endtask

  task automatic set_capacity(logic [CAP_W-1:0] cap);
    @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= cap;
    capacity = cap;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  initial begin
    int phase_cap [NPHASES];
    bit keep_keys [NPHASES];
    int unsigned eff, pool;
    phase_cap = '{1, 0, 31, 5, 16, 3, 12, 2, 16};
    keep_keys = '{0, 0, 0, 0, 0, 1, 0, 0, 0};
    capacity = CAP_RESET;
    slots_used = 0;
    for (int i = 0; i < NSLOTS; i++) begin
      slot_valid[i] = 1'b0;
      slot_age[i] = 0;
    end
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // directed: empty lookup, extreme keys and values, update, first eviction
    push_op(FUNC_LOOKUP, 32'h0000_0000, 32'h0);
    push_op(FUNC_WRITE, 32'h8000_0000, 32'h7FFF_FFFF);
    push_op(FUNC_WRITE, 32'h7FFF_FFFF, 32'h8000_0000);
    push_op(FUNC_WRITE, 32'h0000_0000, 32'h0000_0000);
    push_op(FUNC_WRITE, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    push_op(FUNC_LOOKUP, 32'h8000_0000, 32'h0);
    push_op(FUNC_LOOKUP, 32'h7FFF_FFFF, 32'h0);
    push_op(FUNC_LOOKUP, 32'h0000_0000, 32'hFFFF_FFFF);
    push_op(FUNC_LOOKUP, 32'hFFFF_FFFF, 32'h0);
    push_op(FUNC_LOOKUP, 32'h0000_0001, 32'h0);
    push_op(FUNC_WRITE, 32'hFFFF_FFFF, 32'h0000_1234);
    push_op(FUNC_LOOKUP, 32'hFFFF_FFFF, 32'h0);
    for (int k = 0; k < 13; k++) push_op(FUNC_WRITE, 32'h100 + k, ~k);
    push_op(FUNC_LOOKUP, 32'h7FFF_FFFF, 32'h0);
    push_op(FUNC_LOOKUP, 32'h100, 32'h0);
    wait_idle();

    // random phases; capacity drops below the fill level after the full phase
    for (int p = 0; p < NPHASES; p++) begin
      set_capacity(CAP_W'(phase_cap[p]));
      if (!keep_keys[p]) key_base = $urandom();
      eff = (phase_cap[p] == 0) ? 1 : (phase_cap[p] > NSLOTS) ? NSLOTS : phase_cap[p];
      pool = eff + 4;
      for (int n = 0; n < 220; n++) pending_ops.push_back(random_op(pool));
      wait_idle();
    end

    $display("covered %0d lookups (%0d hits), %0d writes, %0d evictions", n_lookups, n_hits,
             n_writes, n_evictions);
    $display("capacities 16, 1, 0, 31, 5, 16, 3 (below fill), 12, 2, 16; %0d mismatches",
             mismatches);
    if (mismatches == 0 && lookup_expect.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

[files.f]
src/lkvc_pkg.sv
src/lkvc_ram.sv
src/lru_key_value_cache_core.sv
dv/tb_lru_key_value_cache_core.sv
